FILE: sv/qrs_pkg.sv
package qrs_pkg;

  localparam int CoefW    = 16;
  localparam int OutW     = 32;
  localparam int OutFrac  = 16;
  // |b*b - 4ac| fits in 2*CoefW+1 bits
  localparam int DiscW    = 2 * CoefW + 1;
  localparam int RadPairs = (DiscW + 1) / 2;
  localparam int RadW     = 2 * RadPairs;
  localparam int RootW    = RadPairs;
  localparam int SqRemW   = RootW + 2;
  // magnitude of -b +/- s
  localparam int NumW     = RootW + 1;
  localparam int DvdW     = NumW + OutFrac;
  // magnitude of 2a
  localparam int DivW     = CoefW + 1;
  localparam int DvRemW   = DivW + 1;
  localparam int Lanes    = 3;
  localparam int LaneFirst  = 0;
  localparam int LaneSecond = 1;
  localparam int LaneImag   = 2;

  typedef enum logic [1:0] {
    CASE_TWO_REAL  = 2'd0,
    CASE_REPEATED  = 2'd1,
    CASE_COMPLEX   = 2'd2,
    CASE_LEAD_ZERO = 2'd3
  } root_case_t;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
  } coef_word_t;

  typedef struct packed {
    root_case_t             root_case;
    logic signed [OutW-1:0] root_first;
    logic signed [OutW-1:0] root_second;
    logic signed [OutW-1:0] imag_part;
    logic                   saturated;
  } root_word_t;

  typedef struct packed {
    logic [DvRemW-1:0] rem;
    logic [DvdW-1:0]   dvd;
    logic              neg;
  } div_lane_t;

endpackage

FILE: sv/quadratic_root_solver_unit.sv
// Quadratic root solver: takes signed Q8.8 coefficients a, b, c and returns the case code
// and Q16.16 roots of a*x^2 + b*x + c. One word is taken every cycle while no valid result
// is stalled; each word passes through two multiply and discriminant stages, 17 stages of
// the bit-pair square root, one numerator stage, 34 stages of the three-lane restoring
// divider, and the clamp/output register. A stall on the result side holds the whole
// pipeline, so no word is lost or repeated.
module quadratic_root_solver_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                coef_valid,
  output logic                coef_stall,
  input  qrs_pkg::coef_word_t coef,
  output logic                root_valid,
  input  logic                root_stall,
  output qrs_pkg::root_word_t root
);

  localparam int CoefW    = qrs_pkg::CoefW;
  localparam int OutW     = qrs_pkg::OutW;
  localparam int OutFrac  = qrs_pkg::OutFrac;
  localparam int DiscW    = qrs_pkg::DiscW;
  localparam int RadPairs = qrs_pkg::RadPairs;
  localparam int RadW     = qrs_pkg::RadW;
  localparam int RootW    = qrs_pkg::RootW;
  localparam int SqRemW   = qrs_pkg::SqRemW;
  localparam int NumW     = qrs_pkg::NumW;
  localparam int DvdW     = qrs_pkg::DvdW;
  localparam int DivW     = qrs_pkg::DivW;
  localparam int DvRemW   = qrs_pkg::DvRemW;
  localparam int Lanes    = qrs_pkg::Lanes;

  logic adv;
  assign adv        = !root_valid || !root_stall;
  assign coef_stall = !adv;

  // products
  logic                      s1_valid;
  logic signed [CoefW-1:0]   s1_a;
  logic signed [CoefW-1:0]   s1_b;
  logic signed [2*CoefW-1:0] s1_bsq;
  logic signed [2*CoefW-1:0] s1_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= coef_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a   <= coef.coef_a;
      s1_b   <= coef.coef_b;
      s1_bsq <= coef.coef_b * coef.coef_b;
      s1_ac  <= coef.coef_a * coef.coef_c;
    end
  end

  // discriminant and case
  logic [DiscW+1:0] disc;
  logic [DiscW+1:0] disc_mag;
  logic             disc_neg;
  qrs_pkg::root_case_t case_c;

  assign disc     = {3'b000, s1_bsq} - ({{3{s1_ac[2*CoefW-1]}}, s1_ac} << 2);
  assign disc_neg = disc[DiscW+1];
  assign disc_mag = disc_neg ? -disc : disc;

  always_comb begin
    priority if (s1_a == '0) begin
      case_c = qrs_pkg::CASE_LEAD_ZERO;
    end else if (disc_neg) begin
      case_c = qrs_pkg::CASE_COMPLEX;
    end else if (disc == '0) begin
      case_c = qrs_pkg::CASE_REPEATED;
    end else begin
      case_c = qrs_pkg::CASE_TWO_REAL;
    end
  end

  // square root pipeline, index 0 holds the discriminant stage
  logic                    sq_valid [0:RadPairs];
  qrs_pkg::root_case_t     sq_case  [0:RadPairs];
  logic signed [CoefW-1:0] sq_a     [0:RadPairs];
  logic signed [CoefW-1:0] sq_b     [0:RadPairs];
  logic [RadW-1:0]         sq_rad   [0:RadPairs];
  logic [SqRemW-1:0]       sq_rem   [0:RadPairs];
  logic [RootW-1:0]        sq_root  [0:RadPairs];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (adv) begin
      sq_valid[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_case[0] <= case_c;
      sq_a[0]    <= s1_a;
      sq_b[0]    <= s1_b;
      sq_rad[0]  <= RadW'(disc_mag[DiscW-1:0]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar i = 0; i < RadPairs; i++) begin : g_sqrt
    logic [SqRemW-1:0] rem_sh;
    logic [SqRemW-1:0] trial;
    logic              ge;

    assign rem_sh = {sq_rem[i][SqRemW-3:0], sq_rad[i][RadW-1 -: 2]};
    assign trial  = {sq_root[i], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[i+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[i+1] <= sq_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_case[i+1] <= sq_case[i];
        sq_a[i+1]    <= sq_a[i];
        sq_b[i+1]    <= sq_b[i];
        sq_rad[i+1]  <= {sq_rad[i][RadW-3:0], 2'b00};
        sq_rem[i+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root[i+1] <= {sq_root[i][RootW-2:0], ge};
      end
    end
  end

  // numerators and divisor, index 0 of the divider pipeline
  logic signed [NumW:0] neg_b;
  logic signed [NumW:0] root_s;
  logic signed [NumW:0] num  [Lanes];
  logic [CoefW:0]       a_ext;
  logic [CoefW:0]       a_mag;
  logic                 a_neg;

  assign neg_b  = -(NumW+1)'(sq_b[RadPairs]);
  assign root_s = $signed({2'b00, sq_root[RadPairs]});
  assign a_neg  = sq_a[RadPairs][CoefW-1];
  assign a_ext  = {a_neg, sq_a[RadPairs]};
  assign a_mag  = a_neg ? -a_ext : a_ext;

  always_comb begin
    if (sq_case[RadPairs] == qrs_pkg::CASE_TWO_REAL) begin
      num[qrs_pkg::LaneFirst]  = neg_b + root_s;
      num[qrs_pkg::LaneSecond] = neg_b - root_s;
    end else begin
      num[qrs_pkg::LaneFirst]  = neg_b;
      num[qrs_pkg::LaneSecond] = neg_b;
    end
    num[qrs_pkg::LaneImag] = root_s;
  end

  logic                dv_valid [0:DvdW];
  qrs_pkg::root_case_t dv_case  [0:DvdW];
  logic [DivW-1:0]     dv_div   [0:DvdW];
  qrs_pkg::div_lane_t  dv_lane  [0:DvdW][Lanes];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= sq_valid[RadPairs];
    end
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_num
    logic [NumW:0] mag;
    logic          sgn;

    assign sgn = num[k][NumW];
    assign mag = sgn ? -num[k] : num[k];

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_lane[0][k].rem <= '0;
        dv_lane[0][k].dvd <= {mag[NumW-1:0], {OutFrac{1'b0}}};
        dv_lane[0][k].neg <= (k == qrs_pkg::LaneImag) ? sgn : (sgn ^ a_neg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_case[0] <= sq_case[RadPairs];
      dv_div[0]  <= {a_mag[CoefW-1:0], 1'b0};
    end
  end

  // restoring divider, quotient bits shift in behind the dividend
  for (genvar i = 0; i < DvdW; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[i+1] <= dv_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_case[i+1] <= dv_case[i];
        dv_div[i+1]  <= dv_div[i];
      end
    end

    for (genvar k = 0; k < Lanes; k++) begin : g_lane
      logic [DvRemW-1:0] rem_sh;
      logic [DvRemW-1:0] dsr;
      logic              ge;

      assign rem_sh = {dv_lane[i][k].rem[DvRemW-2:0], dv_lane[i][k].dvd[DvdW-1]};
      assign dsr    = {1'b0, dv_div[i]};
      assign ge     = rem_sh >= dsr;

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_lane[i+1][k].rem <= ge ? rem_sh - dsr : rem_sh;
          dv_lane[i+1][k].dvd <= {dv_lane[i][k].dvd[DvdW-2:0], ge};
          dv_lane[i+1][k].neg <= dv_lane[i][k].neg;
        end
      end
    end
  end

  // clamp to Q16.16
  localparam logic [DvdW-1:0] LimPos = (DvdW'(1) << (OutW - 1)) - DvdW'(1);
  localparam logic [DvdW-1:0] LimNeg = DvdW'(1) << (OutW - 1);

  logic [OutW-1:0] lane_val [Lanes];
  logic            lane_sat [Lanes];

  for (genvar k = 0; k < Lanes; k++) begin : g_clamp
    logic [DvdW-1:0] q;
    logic            neg;

    assign q   = dv_lane[DvdW][k].dvd;
    assign neg = dv_lane[DvdW][k].neg;

    always_comb begin
      lane_sat[k] = neg ? (q > LimNeg) : (q > LimPos);
      if (lane_sat[k]) begin
        lane_val[k] = neg ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
      end else begin
        lane_val[k] = neg ? -q[OutW-1:0] : q[OutW-1:0];
      end
    end
  end

  qrs_pkg::root_word_t root_next;

  always_comb begin
    root_next.root_case   = dv_case[DvdW];
    root_next.root_first  = lane_val[qrs_pkg::LaneFirst];
    root_next.root_second = lane_val[qrs_pkg::LaneFirst];
    root_next.imag_part   = '0;
    root_next.saturated   = lane_sat[qrs_pkg::LaneFirst];
    unique case (dv_case[DvdW])
      qrs_pkg::CASE_TWO_REAL: begin
        root_next.root_second = lane_val[qrs_pkg::LaneSecond];
        root_next.saturated   = lane_sat[qrs_pkg::LaneFirst] | lane_sat[qrs_pkg::LaneSecond];
      end
      qrs_pkg::CASE_REPEATED: begin
      end
      qrs_pkg::CASE_COMPLEX: begin
        root_next.imag_part = lane_val[qrs_pkg::LaneImag];
        root_next.saturated = lane_sat[qrs_pkg::LaneFirst] | lane_sat[qrs_pkg::LaneImag];
      end
      qrs_pkg::CASE_LEAD_ZERO: begin
        root_next.root_first  = '0;
        root_next.root_second = '0;
        root_next.saturated   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (adv) begin
      root_valid <= dv_valid[DvdW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root <= root_next;
    end
  end

endmodule

FILE: tb/tb_quadratic_root_solver_unit.sv
`timescale 1ns / 1ps
module tb_quadratic_root_solver_unit;

  localparam int Latency = 55;
  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic coef_valid = 1'b0;
  logic coef_stall;
  qrs_pkg::coef_word_t coef = '0;
  logic root_valid;
  logic root_stall = 1'b0;
  qrs_pkg::root_word_t root;

  qrs_pkg::root_word_t pending_roots[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int rx_wait = 0;
  bit stall_random = 1'b1;

  always #5 clk = ~clk;

  quadratic_root_solver_unit dut (
    .clk(clk), .rst(rst), .coef_valid(coef_valid), .coef_stall(coef_stall),
    .coef(coef), .root_valid(root_valid), .root_stall(root_stall), .root(root)
  );

  // scaled quotient with truncation toward zero and clamp to q16.16
  function automatic logic [31:0] scaled_div(longint num, longint den, ref bit sat);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
      sat = 1'b1;
    end
    if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
      sat = 1'b1;
    end
    return q[31:0];
  endfunction

  function automatic qrs_pkg::root_word_t solve_roots(qrs_pkg::coef_word_t w);
    qrs_pkg::root_word_t r;
    longint a, b, c, disc, mag, s, den;
    bit sat;
    a = w.coef_a;
    b = w.coef_b;
    c = w.coef_c;
    sat = 1'b0;
    r = '0;
    if (a == 0) begin
      r.root_case = qrs_pkg::CASE_LEAD_ZERO;
      return r;
    end
    disc = b * b - 4 * a * c;
    mag = (disc < 0) ? -disc : disc;
    s = 0;
    // floor square root, bit by bit
    for (int k = 16; k >= 0; k--) begin
      if ((s + (64'sd1 << k)) * (s + (64'sd1 << k)) <= mag) s = s + (64'sd1 << k);
    end
    den = 2 * a;
    if (disc > 0) begin
      r.root_case = qrs_pkg::CASE_TWO_REAL;
      r.root_first = scaled_div(-b + s, den, sat);
      r.root_second = scaled_div(-b - s, den, sat);
    end else begin
      r.root_case = (disc == 0) ? qrs_pkg::CASE_REPEATED : qrs_pkg::CASE_COMPLEX;
      r.root_first = scaled_div(-b, den, sat);
      r.root_second = r.root_first;
      if (disc < 0) r.imag_part = scaled_div(s, (den < 0) ? -den : den, sat);
    end
    r.saturated = sat;
    return r;
  endfunction

  // valid stays high after a word is taken; the next word or the gap replaces it
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c, bit idle);
    qrs_pkg::coef_word_t w;
    int gap;
    w.coef_a = a;
    w.coef_b = b;
    w.coef_c = c;
    gap = idle ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      coef_valid <= 1'b0;
      @(posedge clk);
    end
    coef_valid <= 1'b1;
    coef <= w;
    @(posedge clk);
    while (coef_stall) @(posedge clk);
    pending_roots.push_back(solve_roots(w));
  endtask

  // receiver side: random wait per word, or a long hold-off when requested
  always @(posedge clk) begin : rx_side
    int draw;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      root_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      root_stall <= 1'b1;
    end else if (stall_random && root_valid && !root_stall) begin
      draw = $urandom_range(0, 5);
      root_stall <= (draw != 0);
      rx_wait <= (draw > 0) ? draw - 1 : 0;
    end else begin
      root_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && root_valid && !root_stall) begin
      if (pending_roots.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %p", root);
      end else begin
        if (root !== pending_roots[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %p actual %p", pending_roots[0], root);
        end
        void'(pending_roots.pop_front());
      end
    end
  end

  task automatic test_directed();
    logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000};
    send_coefs(16'h0000, 16'h1234, 16'h5678, 1'b1);   // leading zero
    send_coefs(16'h0100, 16'hfe00, 16'h0100, 1'b1);   // repeated root
    send_coefs(16'h0100, 16'h0000, 16'h0100, 1'b1);   // complex pair
    send_coefs(16'h0100, 16'h0000, 16'hff00, 1'b1);   // two real
    send_coefs(16'h0001, 16'h0001, 16'h0000, 1'b1);   // tiny discriminant
    send_coefs(16'h0001, 16'h7fff, 16'h0001, 1'b1);   // large b, roots stay inside the Q16.16 range
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j += 2)
        send_coefs(ext[i], ext[j], ext[3 - j], 1'b1);
  endtask

  task automatic test_random(int count);
    logic [15:0] a, b, c;
    for (int i = 0; i < count; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      case ($urandom_range(0, 5))
        0: a = $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
        1: a = 16'h0000;
        2: begin
          // perfect square so the discriminant is zero
          a = 16'($urandom_range(1, 60));
          c = a;
          b = {a[14:0], 1'b0};
        end
        default: ;
      endcase
      send_coefs(a, b, c, ($urandom_range(0, 3) != 0) && (i % 300 < 250));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    test_random(150);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_backpressure();
    stall_random = 1'b0;
    test_random(300);
    stall_random = 1'b1;
    test_random(650);
    coef_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
